>>> hdl/srb_pkg.sv
`timescale 1ns / 1ps

package srb_pkg;

  // Window depth; slot index is the low bits of the sequence, so keep it a power of two.
  localparam int WINDOW   = 64;
  localparam int SEQ_BITS = 32;
  localparam int IDX_W    = $clog2(WINDOW);
  localparam int CNT_W    = $clog2(WINDOW + 1);
  localparam int GAP_W    = 6;
  localparam int ORD_W    = 32;
  localparam int PRICE_W  = 32;
  localparam int QTY_W    = 32;
  localparam int STAT_W   = 3;
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam int TDATA_BITS = SEQ_BITS + ORD_W + 1 + PRICE_W + QTY_W;
  localparam int TDATA_W    = ((TDATA_BITS + 7) / 8) * 8;
  localparam int TPAD_W     = TDATA_W - TDATA_BITS;
  localparam int S_TUSER_W  = 2;
  localparam int M_TUSER_W  = STAT_W + 1;

  localparam logic [GAP_W-1:0] MAX_GAP_RST = GAP_W'(63);

  localparam logic OP_SUBMIT = 1'b0;
  localparam logic OP_CLOSE  = 1'b1;

  typedef logic [SEQ_BITS-1:0] seq_t;

  typedef enum logic [STAT_W-1:0] {
    STS_RELEASED = 3'd0,
    STS_ZERO     = 3'd1,
    STS_CLOSED   = 3'd2,
    STS_STALE    = 3'd3,
    STS_GAP      = 3'd4,
    STS_DUP      = 3'd5,
    STS_MISSING  = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    CLS_SUBMIT,
    CLS_ZERO,
    CLS_CLOSE
  } class_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_SCAN,
    S_FLUSH
  } fsm_e;

  typedef struct packed {
    logic               kind;
    logic [ORD_W-1:0]   ord_num;
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } cmd_t;

  localparam int CMD_W = $bits(cmd_t);

  typedef struct packed {
    class_e cls;
    seq_t   seq;
    cmd_t   cmd;
  } item_t;

  typedef struct packed {
    seq_t    seq;
    status_e status;
    cmd_t    cmd;
    logic    last;
  } result_t;

endpackage

>>> hdl/srb_ram.sv
`timescale 1ns / 1ps

module srb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/srb_front.sv
`timescale 1ns / 1ps

module srb_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_valid_i,
  output logic           s_ready_o,
  input  logic           op_i,
  input  srb_pkg::seq_t  seq_i,
  input  srb_pkg::cmd_t  cmd_i,
  output logic           head_vld_o,
  output srb_pkg::item_t head_o,
  input  logic           pop_i
);
  import srb_pkg::*;

  item_t             fifo_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d;
  logic [QPTR_W-1:0] rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  item_t             in_item;
  logic              push;
  logic              pop;

  always_comb begin
    in_item.seq = seq_i;
    in_item.cmd = cmd_i;
    if (op_i == OP_CLOSE) begin
      in_item.cls = CLS_CLOSE;
    end else if (seq_i == '0) begin
      in_item.cls = CLS_ZERO;
    end else begin
      in_item.cls = CLS_SUBMIT;
    end
  end

  assign s_ready_o  = (cnt_q != QCNT_W'(QDEPTH));
  assign push       = s_valid_i && s_ready_o;
  assign head_vld_o = (cnt_q != '0);
  assign pop        = pop_i && head_vld_o;
  assign head_o     = fifo_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= in_item;
    end
  end

endmodule

>>> hdl/srb_back.sv
`timescale 1ns / 1ps

module srb_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [srb_pkg::GAP_W-1:0] cfg_wdata_i,
  input  logic                     head_vld_i,
  input  srb_pkg::item_t           head_i,
  output logic                     pop_o,
  output logic                     m_valid_o,
  input  logic                     m_ready_i,
  output srb_pkg::result_t         res_o
);
  import srb_pkg::*;

  fsm_e              state_q, state_d;
  seq_t              ne_q, ne_d;
  logic              acc_q, acc_d;
  logic [WINDOW-1:0] valid_q, valid_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [GAP_W-1:0]  gap_q;
  logic [IDX_W-1:0]  off_q, off_d;
  result_t           out_q, out_d;
  logic              out_vld_q;
  logic              emit;

  logic              out_free;
  seq_t              gap_eff;
  seq_t              diff;
  status_e           status_c;
  logic [IDX_W-1:0]  ne_idx, nxt_idx, seq_idx, scan_idx;
  logic              ne_max, run_last, hit_ne, flush_last;
  logic              pop;

  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  cmd_t              ram_rdata;

  assign out_free   = !out_vld_q || m_ready_i;
  assign gap_eff    = (SEQ_BITS'(gap_q) < SEQ_BITS'(WINDOW - 1)) ? SEQ_BITS'(gap_q)
                                                               : SEQ_BITS'(WINDOW - 1);
  assign diff       = head_i.seq - ne_q;
  assign ne_idx     = ne_q[IDX_W-1:0];
  assign nxt_idx    = ne_idx + 1'b1;
  assign seq_idx    = head_i.seq[IDX_W-1:0];
  assign scan_idx   = ne_idx + off_q;
  assign ne_max     = &ne_q;
  // run stops when the next slot is empty or the sequence space is used up
  assign run_last   = ne_max || !valid_q[nxt_idx];
  assign hit_ne     = (head_i.seq == ne_q);
  assign flush_last = (cnt_q == CNT_W'(1));
  assign pop        = (state_q == S_IDLE) && head_vld_i && out_free;
  assign pop_o      = pop;

  always_comb begin
    if (head_i.cls == CLS_ZERO) begin
      status_c = STS_ZERO;
    end else if (!acc_q) begin
      status_c = STS_CLOSED;
    end else if (head_i.seq < ne_q) begin
      status_c = STS_STALE;
    end else if (diff > gap_eff) begin
      status_c = STS_GAP;
    end else if (!hit_ne && valid_q[seq_idx]) begin
      status_c = STS_DUP;
    end else begin
      status_c = STS_RELEASED;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (pop) begin
          if (head_i.cls == CLS_CLOSE) begin
            if (cnt_q != '0) begin
              state_d = S_SCAN;
            end
          end else if (status_c == STS_RELEASED && hit_ne && !run_last) begin
            state_d = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (out_free && run_last) begin
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        if (valid_q[scan_idx]) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          state_d = flush_last ? S_IDLE : S_SCAN;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    ne_d      = ne_q;
    acc_d     = acc_q;
    valid_d   = valid_q;
    cnt_d     = cnt_q;
    off_d     = off_q;
    out_d     = out_q;
    emit      = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = nxt_idx;
    case (state_q)
      S_IDLE: begin
        if (pop) begin
          if (head_i.cls == CLS_CLOSE) begin
            acc_d = 1'b0;
            off_d = IDX_W'(1);
          end else if (status_c != STS_RELEASED) begin
            emit       = 1'b1;
            out_d.seq    = head_i.seq;
            out_d.status = status_c;
            out_d.cmd    = head_i.cmd;
            out_d.last   = 1'b1;
          end else if (!hit_ne) begin
            ram_we           = 1'b1;
            valid_d[seq_idx] = 1'b1;
            cnt_d            = cnt_q + 1'b1;
          end else begin
            emit         = 1'b1;
            out_d.seq    = head_i.seq;
            out_d.status = STS_RELEASED;
            out_d.cmd    = head_i.cmd;
            out_d.last   = run_last;
            if (ne_max) begin
              acc_d = 1'b0;
            end else begin
              ne_d = ne_q + 1'b1;
            end
            ram_re = !run_last;
          end
        end
      end
      S_RUN: begin
        if (out_free) begin
          emit            = 1'b1;
          out_d.seq       = ne_q;
          out_d.status    = STS_RELEASED;
          out_d.cmd       = ram_rdata;
          out_d.last      = run_last;
          valid_d[ne_idx] = 1'b0;
          cnt_d           = cnt_q - 1'b1;
          if (ne_max) begin
            acc_d = 1'b0;
          end else begin
            ne_d = ne_q + 1'b1;
          end
          ram_re = !run_last;
        end
      end
      S_SCAN: begin
        ram_raddr = scan_idx;
        if (valid_q[scan_idx]) begin
          ram_re = 1'b1;
        end else begin
          off_d = off_q + 1'b1;
        end
      end
      S_FLUSH: begin
        ram_raddr = scan_idx;
        if (out_free) begin
          emit              = 1'b1;
          out_d.seq         = ne_q + SEQ_BITS'(off_q);
          out_d.status      = STS_MISSING;
          out_d.cmd         = ram_rdata;
          out_d.last        = flush_last;
          valid_d[scan_idx] = 1'b0;
          cnt_d             = cnt_q - 1'b1;
          off_d             = off_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ne_q      <= SEQ_BITS'(1);
      acc_q     <= 1'b1;
      valid_q   <= '0;
      cnt_q     <= '0;
      off_q     <= '0;
      gap_q     <= MAX_GAP_RST;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ne_q    <= ne_d;
      acc_q   <= acc_d;
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
      off_q   <= off_d;
      if (cfg_we_i) begin
        gap_q <= cfg_wdata_i;
      end
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (m_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  srb_ram #(
    .WIDTH (CMD_W),
    .DEPTH (WINDOW)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (seq_idx),
    .wdata_i (head_i.cmd),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign m_valid_o = out_vld_q;
  assign res_o     = out_q;

endmodule

>>> hdl/sequence_reorder_buffer.sv
`timescale 1ns / 1ps

// Sequence-number reorder buffer.
// Slave stream takes commands: tuser selects submit or close and carries the command
// kind, tdata carries sequence number and order payload. Master stream returns one
// result item per released, rejected or flushed command; tlast marks the final result
// caused by one input item. cfg_we_i writes the max_gap register (reset 63).
// A submit is classified and either stored in a 64-slot window, echoed back with an
// error status, or released together with every contiguous held successor.
// An accepted command waits in the input queue; its first result goes to the result
// register. A stored or rejected command is handled as it is popped; a released run
// emits one item per cycle after the first while the receiver is ready (slot RAM read
// runs one ahead); a close scans the window one slot per cycle, then flushes each hit.
// A two-entry input queue keeps accepting while the engine works or the output waits.
// Reset clears all held slots, sets the expected sequence to one and reopens accepting;
// no clearing pass is needed. When the receiver stalls, the result register holds and
// the engine waits; further inputs wait once the input queue is full.
module sequence_reorder_buffer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [srb_pkg::GAP_W-1:0]       cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // seq, ord_num, side, price, quantity, zero pad
  input  logic [srb_pkg::TDATA_W-1:0]     s_axis_tdata,
  // op, cmd_kind
  input  logic [srb_pkg::S_TUSER_W-1:0]   s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // out_seq, out_ord_num, out_side, out_price, out_quantity, zero pad
  output logic [srb_pkg::TDATA_W-1:0]     m_axis_tdata,
  // status, out_kind
  output logic [srb_pkg::M_TUSER_W-1:0]   m_axis_tuser,
  output logic                            m_axis_tlast
);
  import srb_pkg::*;

  cmd_t    in_cmd;
  seq_t    in_seq;
  item_t   head;
  logic    head_vld;
  logic    pop;
  result_t res;

  assign in_seq         = s_axis_tdata[SEQ_BITS-1:0];
  assign in_cmd.kind    = s_axis_tuser[1];
  assign in_cmd.ord_num = s_axis_tdata[SEQ_BITS +: ORD_W];
  assign in_cmd.side    = s_axis_tdata[SEQ_BITS + ORD_W];
  assign in_cmd.price   = s_axis_tdata[SEQ_BITS + ORD_W + 1 +: PRICE_W];
  assign in_cmd.qty     = s_axis_tdata[SEQ_BITS + ORD_W + 1 + PRICE_W +: QTY_W];

  srb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .op_i       (s_axis_tuser[0]),
    .seq_i      (in_seq),
    .cmd_i      (in_cmd),
    .head_vld_o (head_vld),
    .head_o     (head),
    .pop_i      (pop)
  );

  srb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .head_vld_i  (head_vld),
    .head_i      (head),
    .pop_o       (pop),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {{TPAD_W{1'b0}}, res.cmd.qty, res.cmd.price, res.cmd.side,
                         res.cmd.ord_num, res.seq};
  assign m_axis_tuser = {res.cmd.kind, res.status};
  assign m_axis_tlast = res.last;

endmodule
